### rtl/vru_pkg.sv
// package with parse phases, record kinds and error codes of the subevent unpacker
`default_nettype none
package vru_pkg;
	localparam int TdcChannels      = 32;
	localparam int MaxHits          = 10;
	localparam int FirstHitChannels = 16;

	localparam logic [31:0] BarrierWord = 32'hbabababa;
	localparam logic [9:0]  TsLimit     = 10'd15;
	localparam logic [9:0]  PosMax      = 10'd1023;

	typedef enum logic [3:0] {
		PH_IDLE, PH_S_HDR, PH_S_DATA, PH_Q_HDR, PH_Q_DATA, PH_Q_EOB, PH_TS, PH_BAR1,
		PH_TDC_GLB, PH_TDC_BODY, PH_TDC_AFTER, PH_BAR3, PH_M_HDR, PH_M_DATA
	} phase_t;

	typedef enum logic [3:0] {
		RK_C30_SCALER = 4'd0, RK_C30_QDC = 4'd1, RK_TIMESTAMP = 4'd2, RK_MAIN_SCALER = 4'd3,
		RK_TDC_LEAD = 4'd4, RK_TDC_TRAIL = 4'd5, RK_MAIN_QDC = 4'd6, RK_C20_QDC = 4'd7,
		RK_C25_QDC = 4'd8, RK_FH_ADC = 4'd9, RK_FH_TDC = 4'd10, RK_ERROR = 4'd11
	} kind_t;

	typedef enum logic [2:0] {
		ER_NONE = 3'd0, ER_BARRIER = 3'd1, ER_SCALER_TYPE = 3'd2, ER_TDC_WORD = 3'd3,
		ER_TDC_SLOT = 3'd4
	} err_t;

	localparam logic [5:0] Crate10 = 6'd10;
	localparam logic [5:0] Crate20 = 6'd20;
	localparam logic [5:0] Crate25 = 6'd25;
	localparam logic [5:0] Crate30 = 6'd30;
	localparam logic [5:0] Crate40 = 6'd40;

	typedef struct packed {
		logic [3:0]  kind;
		logic [4:0]  slot;
		logic [4:0]  chan;
		logic [5:0]  idx;
		logic [31:0] val;
		logic [2:0]  err;
	} rec_t;
endpackage
`default_nettype wire

### rtl/vru_ram.sv
// generic single-port-write, one-read ram with registered read data
`default_nettype none
module vru_ram #(
	parameter int Width = 4,
	parameter int Depth = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/vme_readout_subevent_unpacker_top.sv
// top level of the vme readout subevent unpacker
// path: an accepted word is registered in stage 1, its record in the output register
// throughput: one word per cycle unless m_axis stalls; hit counts sit in a ram read
// one word ahead with forwarding from the write stage, first-hit flags in flip-flops
// a valid bit per hit-count entry, cleared at each new event, masks stale ram data
// reset: asynchronous, all control state cleared, usable right after release
`default_nettype none
module vme_readout_subevent_unpacker_top #(
	parameter int TdcChannels      = vru_pkg::TdcChannels,
	parameter int MaxHits          = vru_pkg::MaxHits,
	parameter int FirstHitChannels = vru_pkg::FirstHitChannels
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// data_word[31:0], crate_id[37:32], subevent_words[47:38]
	input  wire  [47:0] s_axis_tdata,
	// first_word[0], new_event[1], timestamp_kind[2]
	input  wire  [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// module_slot[4:0], channel[9:5], entry_index[15:10], value[47:16], error_code[50:48]
	output logic [55:0] m_axis_tdata,
	// record_kind[3:0]
	output logic [3:0]  m_axis_tuser
);
	// stage 1: registered input word, hit-count ram read in flight
	logic        v_s1;
	logic [31:0] w_s1;
	logic        first_s1, newev_s1, tsk_s1;
	logic [5:0]  crate_s1;
	logic [9:0]  len_s1;

	// pipeline advance: stage-1 word processed when the output slot is free or being read
	logic out_full_q;
	logic adv;
	assign adv = !out_full_q || m_axis_tready;
	assign s_axis_tready = adv;
	wire acc = s_axis_tvalid && s_axis_tready;

	// ram read address from the incoming word
	wire [31:0] w_in = s_axis_tdata[31:0];
	wire [5:0]  k_in = {w_in[25:21], w_in[26]};

	logic [3:0] rdata;
	logic       ram_we;
	logic [5:0] ram_wa;
	logic [3:0] ram_wd;

	vru_ram #(.Width(4), .Depth(64)) u_hits (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(k_in), .rdata(rdata)
	);

	// entries not written since the last new event read as zero
	logic [63:0] hv_q, hv_d;
	// forwarding of the write made by the previous stage-1 word
	logic       fwd_v_q;
	logic [5:0] fwd_a_q;
	logic [3:0] fwd_d_q;

	vru_pkg::phase_t ph_q, ph_d;
	logic [9:0] left_q, left_d;
	logic [5:0] bidx_q, bidx_d;
	logic [4:0] tslot_q, tslot_d;
	logic [5:0] crate_q, crate_d;
	logic [9:0] pos_q, pos_d;
	logic [31:0] fh_q, fh_d;

	vru_pkg::rec_t rec;
	logic rec_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1     <= w_in;
			crate_s1 <= s_axis_tdata[37:32];
			len_s1   <= s_axis_tdata[47:38];
			first_s1 <= s_axis_tuser[0];
			newev_s1 <= s_axis_tuser[1];
			tsk_s1   <= s_axis_tuser[2];
		end
	end

	// the ram read is issued every cycle; hold the read data while stalled
	logic [3:0] rd_hold_q;
	logic       stall_q;
	logic [3:0] rd_eff;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_q <= 1'b0;
		end else begin
			stall_q <= !adv;
		end
	end
	always_ff @(posedge clk) begin
		rd_hold_q <= rd_eff;
	end

	wire [5:0] k_s1 = {w_s1[25:21], w_s1[26]};
	always_comb begin
		rd_eff = stall_q ? rd_hold_q : rdata;
		if (fwd_v_q && fwd_a_q == k_s1) begin
			rd_eff = fwd_d_q;
		end
	end

	always_comb begin
		logic       in_len;
		logic [3:0] hits;
		logic [4:0] chn;
		logic [5:0] fch;
		logic [4:0] fidx;
		logic [4:0] flag;
		logic       do_tdc;
		logic       bar2;
		ph_d    = ph_q;
		left_d  = left_q;
		bidx_d  = bidx_q;
		tslot_d = tslot_q;
		crate_d = crate_q;
		pos_d   = pos_q;
		fh_d    = fh_q;
		hv_d    = hv_q;
		rec     = '0;
		rec_v   = 1'b0;
		ram_we  = 1'b0;
		ram_wa  = k_s1;
		ram_wd  = '0;
		in_len  = pos_q < len_s1;
		hits    = hv_q[k_s1] ? rd_eff : 4'd0;
		chn     = w_s1[25:21];
		fch     = w_s1[21:16];
		fidx    = '0;
		flag    = '0;
		do_tdc  = 1'b0;
		bar2    = 1'b0;
		if (first_s1) begin
			if (newev_s1) begin
				fh_d = '0;
				hv_d = '0;
			end
			crate_d = crate_s1;
			pos_d   = 10'd1;
			bidx_d  = '0;
			left_d  = '0;
			case (crate_s1)
				vru_pkg::Crate30: ph_d = vru_pkg::PH_S_HDR;
				vru_pkg::Crate10: ph_d = (tsk_s1 && len_s1 < vru_pkg::TsLimit) ?
					vru_pkg::PH_TS : vru_pkg::PH_BAR1;
				vru_pkg::Crate20, vru_pkg::Crate25: ph_d = vru_pkg::PH_Q_HDR;
				vru_pkg::Crate40: ph_d = vru_pkg::PH_M_HDR;
				default: ph_d = vru_pkg::PH_IDLE;
			endcase
		end else begin
			unique case (ph_q)
				vru_pkg::PH_TS: begin
					if (!in_len) ph_d = vru_pkg::PH_IDLE;
					else begin
						rec_v = 1'b1;
						rec.kind = vru_pkg::RK_TIMESTAMP;
						rec.idx = 6'(pos_q - 10'd1);
						rec.val = w_s1;
					end
				end
				vru_pkg::PH_S_HDR: begin
					left_d = {4'd0, w_s1[23:18]};
					bidx_d = '0;
					ph_d = (w_s1[23:18] != 6'd0) ? vru_pkg::PH_S_DATA : vru_pkg::PH_Q_HDR;
					if (w_s1[26:24] != 3'd4) begin
						rec_v = 1'b1;
						rec.kind = vru_pkg::RK_ERROR;
						rec.slot = w_s1[31:27];
						rec.val = w_s1;
						rec.err = vru_pkg::ER_SCALER_TYPE;
					end
				end
				vru_pkg::PH_S_DATA: begin
					rec_v = 1'b1;
					rec.kind = (crate_q == vru_pkg::Crate10) ? vru_pkg::RK_MAIN_SCALER :
						vru_pkg::RK_C30_SCALER;
					rec.idx = bidx_q;
					rec.val = w_s1;
					bidx_d = bidx_q + 6'd1;
					if (left_q != 10'd0) left_d = left_q - 10'd1;
					if (left_d == 10'd0) ph_d = vru_pkg::PH_Q_HDR;
				end
				vru_pkg::PH_Q_HDR: begin
					if (!in_len) ph_d = vru_pkg::PH_IDLE;
					else if (w_s1[26:24] == 3'd2 && w_s1[13:8] != 6'd0) begin
						left_d = {4'd0, w_s1[13:8]};
						ph_d = vru_pkg::PH_Q_DATA;
					end else if (crate_q != vru_pkg::Crate10) begin
						ph_d = vru_pkg::PH_Q_EOB;
					end
				end
				vru_pkg::PH_Q_DATA: begin
					rec_v = 1'b1;
					case (crate_q)
						vru_pkg::Crate10: rec.kind = vru_pkg::RK_MAIN_QDC;
						vru_pkg::Crate20: rec.kind = vru_pkg::RK_C20_QDC;
						vru_pkg::Crate25: rec.kind = vru_pkg::RK_C25_QDC;
						default: rec.kind = vru_pkg::RK_C30_QDC;
					endcase
					rec.slot = w_s1[31:27];
					rec.chan = w_s1[20:16];
					rec.val = {16'd0, w_s1[15:0]};
					if (left_q != 10'd0) left_d = left_q - 10'd1;
					if (left_d == 10'd0) ph_d = vru_pkg::PH_Q_EOB;
				end
				vru_pkg::PH_Q_EOB: ph_d = vru_pkg::PH_Q_HDR;
				vru_pkg::PH_BAR1: begin
					ph_d = vru_pkg::PH_TDC_GLB;
					if (w_s1 != vru_pkg::BarrierWord) begin
						rec_v = 1'b1;
						rec.kind = vru_pkg::RK_ERROR;
						rec.val = w_s1;
						rec.err = vru_pkg::ER_BARRIER;
					end
				end
				vru_pkg::PH_TDC_GLB: begin
					if (!in_len) bar2 = 1'b1;
					else begin
						tslot_d = w_s1[4:0];
						ph_d = (w_s1[31:27] == 5'd8) ? vru_pkg::PH_TDC_BODY : vru_pkg::PH_BAR3;
					end
				end
				vru_pkg::PH_TDC_BODY: begin
					if (!in_len) bar2 = 1'b1;
					else if (w_s1[31:27] == 5'd1) ph_d = vru_pkg::PH_TDC_AFTER;
					else do_tdc = 1'b1;
				end
				vru_pkg::PH_TDC_AFTER: begin
					ph_d = vru_pkg::PH_TDC_BODY;
					do_tdc = 1'b1;
				end
				vru_pkg::PH_BAR3: bar2 = 1'b1;
				vru_pkg::PH_M_HDR: begin
					left_d = w_s1[9:0];
					ph_d = (w_s1[9:0] != 10'd0) ? vru_pkg::PH_M_DATA : vru_pkg::PH_IDLE;
				end
				vru_pkg::PH_M_DATA: begin
					if (w_s1[31:28] == 4'd1 && fch < 6'd32) begin
						fidx = fch[3:0] + 5'd0;
						flag = fch[4:0];
						if (fidx < 5'(FirstHitChannels) && !fh_q[flag]) begin
							fh_d[flag] = (w_s1[15:0] != 16'd0);
							rec_v = 1'b1;
							rec.kind = fch[4] ? vru_pkg::RK_FH_TDC : vru_pkg::RK_FH_ADC;
							rec.chan = fidx;
							rec.val = {16'd0, w_s1[15:0]};
						end
					end
					if (left_q != 10'd0) left_d = left_q - 10'd1;
					if (left_d == 10'd0) ph_d = vru_pkg::PH_IDLE;
				end
				default: ph_d = vru_pkg::PH_IDLE;
			endcase
			if (bar2) begin
				ph_d = vru_pkg::PH_S_HDR;
				if (w_s1 != vru_pkg::BarrierWord) begin
					rec_v = 1'b1;
					rec.kind = vru_pkg::RK_ERROR;
					rec.val = w_s1;
					rec.err = vru_pkg::ER_BARRIER;
				end
			end
			if (do_tdc) begin
				if (w_s1[31:27] == 5'd0) begin
					if (6'(chn) < 6'(TdcChannels) && hits < 4'(MaxHits)) begin
						ram_we = 1'b1;
						ram_wd = hits + 4'd1;
						hv_d[k_s1] = 1'b1;
						if (w_s1[20:0] != 21'd0) begin
							rec_v = 1'b1;
							rec.kind = w_s1[26] ? vru_pkg::RK_TDC_TRAIL : vru_pkg::RK_TDC_LEAD;
							rec.slot = tslot_q;
							rec.chan = chn;
							rec.idx = {2'd0, hits};
							rec.val = {11'd0, w_s1[20:0]};
						end
					end
				end else if (w_s1[31:27] == 5'd16) begin
					ph_d = vru_pkg::PH_BAR3;
					if (w_s1[4:0] != tslot_q) begin
						rec_v = 1'b1;
						rec.kind = vru_pkg::RK_ERROR;
						rec.slot = tslot_q;
						rec.val = w_s1;
						rec.err = vru_pkg::ER_TDC_SLOT;
					end
				end else if (w_s1[31:27] != 5'd3) begin
					rec_v = 1'b1;
					rec.kind = vru_pkg::RK_ERROR;
					rec.val = w_s1;
					rec.err = vru_pkg::ER_TDC_WORD;
				end
			end
			if (pos_q < vru_pkg::PosMax) pos_d = pos_q + 10'd1;
		end
		if (!(v_s1 && adv)) ram_we = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= vru_pkg::PH_IDLE;
			left_q  <= '0;
			bidx_q  <= '0;
			tslot_q <= '0;
			crate_q <= '0;
			pos_q   <= '0;
			fh_q    <= '0;
			hv_q    <= '0;
			fwd_v_q <= 1'b0;
			fwd_a_q <= '0;
			fwd_d_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (v_s1 && adv) begin
				ph_q    <= ph_d;
				left_q  <= left_d;
				bidx_q  <= bidx_d;
				tslot_q <= tslot_d;
				crate_q <= crate_d;
				pos_q   <= pos_d;
				fh_q    <= fh_d;
				hv_q    <= hv_d;
			end
			if (adv) begin
				fwd_v_q <= ram_we;
				fwd_a_q <= ram_wa;
				fwd_d_q <= ram_wd;
			end
			if (adv) out_full_q <= v_s1 && rec_v;
		end
	end

	vru_pkg::rec_t out_q;
	always_ff @(posedge clk) begin
		if (adv) out_q <= rec;
	end

	assign m_axis_tvalid = out_full_q;
	assign m_axis_tdata  = {5'd0, out_q.err, out_q.val, out_q.idx, out_q.chan, out_q.slot};
	assign m_axis_tuser  = out_q.kind;
endmodule
`default_nettype wire
